### design/complex_frequency_shift_mixer_core_defines.svh
// assertion macros shared by the mixer modules
// no dependencies; included by every module that carries assertions
`ifndef COMPLEX_FREQUENCY_SHIFT_MIXER_CORE_DEFINES_SVH
`define COMPLEX_FREQUENCY_SHIFT_MIXER_CORE_DEFINES_SVH

// same-cycle implication, checks off while reset is held
`define CFSM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checks off while reset is held
`define CFSM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/cfsm_pkg.sv
// shared types, constants and the phasor table generator for the nco mixer
// no dependencies; used by cfsm_nco, cfsm_cmul and the top level
package cfsm_pkg;

    localparam int STEP_BITS = 32;

    localparam longint FX_ONE = 64'sd1000000000;
    localparam longint FX_PI  = 64'sd3141592654;

    // taylor term divisors (2n)(2n+1) and (2n-1)(2n)
    localparam longint SIN_DIV [1:8] = '{6, 20, 42, 72, 110, 156, 210, 272};
    localparam longint COS_DIV [1:8] = '{2, 12, 30, 56, 90, 132, 182, 240};

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } quad_t;

    typedef struct packed {
        logic  valid;
        quad_t quad;
    } phasor_ctl_t;

    // magnitude of sin or cos over one octant, q1.(sample_bits-1), capped at 1.0
    function automatic longint octant_coef(input int r, input int addr_bits,
                                           input int sample_bits, input bit want_sin);
        longint x;
        longint ts;
        longint tc;
        longint ss;
        longint cc;
        longint v;
        longint q;
        longint lim;
        int     n;
        x  = (2 * FX_PI * longint'(r) + (64'sd1 <<< (addr_bits - 1))) >>> addr_bits;
        ts = x;
        tc = FX_ONE;
        ss = x;
        cc = FX_ONE;
        for (n = 1; n <= 8; n++) begin
            ts = ts * x / FX_ONE * x / FX_ONE / SIN_DIV[n];
            tc = tc * x / FX_ONE * x / FX_ONE / COS_DIV[n];
            if (n[0]) begin
                ss = ss - ts;
                cc = cc - tc;
            end else begin
                ss = ss + ts;
                cc = cc + tc;
            end
        end
        v   = want_sin ? ss : cc;
        if (v < 0) v = -v;
        lim = 64'sd1 <<< (sample_bits - 1);
        q   = (v * lim + FX_ONE / 2) / FX_ONE;
        if (q > lim) q = lim;
        return q;
    endfunction

endpackage

### design/cfsm_nco.sv
// phase accumulator, step register and octant phasor lookup
// depends on cfsm_pkg and complex_frequency_shift_mixer_core_defines.svh
`include "complex_frequency_shift_mixer_core_defines.svh"

module cfsm_nco #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [cfsm_pkg::STEP_BITS-1:0]      cfg_wr_data,
    input  logic                                step_en,
    output logic [SAMPLE_BITS-1:0]              sin_mag,
    output logic [SAMPLE_BITS-1:0]              cos_mag,
    output cfsm_pkg::quad_t                     quad
);

    localparam int OCT_BITS  = TABLE_ADDR_BITS - 2;
    localparam int OCT_DEPTH = (1 << (TABLE_ADDR_BITS - 3)) + 1;
    localparam logic [OCT_BITS-1:0] R_HALF    = OCT_BITS'(1 << (TABLE_ADDR_BITS - 3));
    localparam logic [OCT_BITS:0]   R_QUARTER = (OCT_BITS + 1)'(1 << OCT_BITS);

    logic [cfsm_pkg::STEP_BITS-1:0] phase_step_reg;
    logic [PHASE_BITS-1:0]          acc_reg;
    logic [PHASE_BITS-1:0]          acc_next;
    logic [PHASE_BITS-1:0]          step_aligned;

    logic [TABLE_ADDR_BITS-1:0]     tab_idx;
    logic [OCT_BITS-1:0]            oct_r;
    logic [OCT_BITS:0]              oct_flip;
    logic                           swap;
    logic [OCT_BITS-1:0]            oct_idx;

    logic [SAMPLE_BITS-1:0]         sin_rom [OCT_DEPTH];
    logic [SAMPLE_BITS-1:0]         cos_rom [OCT_DEPTH];

    for (genvar g = 0; g < OCT_DEPTH; g++) begin : g_oct
        localparam longint SIN_V = cfsm_pkg::octant_coef(g, TABLE_ADDR_BITS, SAMPLE_BITS, 1'b1);
        localparam longint COS_V = cfsm_pkg::octant_coef(g, TABLE_ADDR_BITS, SAMPLE_BITS, 1'b0);
        assign sin_rom[g] = SIN_V[SAMPLE_BITS-1:0];
        assign cos_rom[g] = COS_V[SAMPLE_BITS-1:0];
    end

    // step is aligned to the top of the accumulator
    if (PHASE_BITS >= cfsm_pkg::STEP_BITS) begin : g_step_up
        assign step_aligned = PHASE_BITS'(phase_step_reg) << (PHASE_BITS - cfsm_pkg::STEP_BITS);
    end else begin : g_step_down
        assign step_aligned = PHASE_BITS'(phase_step_reg >> (cfsm_pkg::STEP_BITS - PHASE_BITS));
    end

    assign acc_next = acc_reg + step_aligned;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg <= '0;
            acc_reg        <= '0;
        end else begin
            if (cfg_wr_en) phase_step_reg <= cfg_wr_data;
            if (step_en)   acc_reg        <= acc_next;
        end
    end

    // fold the quarter wave onto one octant
    always_comb begin
        tab_idx  = acc_reg[PHASE_BITS-1 -: TABLE_ADDR_BITS];
        oct_r    = tab_idx[OCT_BITS-1:0];
        quad     = cfsm_pkg::quad_t'(tab_idx[TABLE_ADDR_BITS-1 -: 2]);
        swap     = oct_r > R_HALF;
        oct_flip = R_QUARTER - {1'b0, oct_r};
        oct_idx  = swap ? oct_flip[OCT_BITS-1:0] : oct_r;
        sin_mag  = swap ? cos_rom[oct_idx] : sin_rom[oct_idx];
        cos_mag  = swap ? sin_rom[oct_idx] : cos_rom[oct_idx];
    end

    `CFSM_ASSERT_NEXT(a_acc_advance, aclk, aresetn, step_en, acc_reg == $past(acc_next), "phase accumulator did not advance by the step")

endmodule

### design/cfsm_cmul.sv
// complex multiply stage and round/saturate output register
// depends on cfsm_pkg and complex_frequency_shift_mixer_core_defines.svh
`include "complex_frequency_shift_mixer_core_defines.svh"

module cfsm_cmul #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cfsm_pkg::phasor_ctl_t         in_ctl,
    input  logic signed [SAMPLE_BITS-1:0] in_real,
    input  logic signed [SAMPLE_BITS-1:0] in_imag,
    input  logic [SAMPLE_BITS-1:0]        sin_mag,
    input  logic [SAMPLE_BITS-1:0]        cos_mag,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_real,
    output logic signed [SAMPLE_BITS-1:0] out_imag
);

    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SH_W   = SAMPLE_BITS + 2;
    localparam logic signed [SUM_W-1:0]       HALF_LSB = SUM_W'(1 << (SAMPLE_BITS - 2));
    localparam logic signed [SAMPLE_BITS-1:0] S_MAX    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN    = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                           b_valid_reg;
    logic                           b_valid_next;
    logic signed [PROD_W-1:0]       prod_rc_reg;
    logic signed [PROD_W-1:0]       prod_is_reg;
    logic signed [PROD_W-1:0]       prod_rs_reg;
    logic signed [PROD_W-1:0]       prod_ic_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic signed [SAMPLE_BITS-1:0]  out_real_reg;
    logic signed [SAMPLE_BITS-1:0]  out_imag_reg;

    logic                           out_free;
    logic                           b_move;
    logic [SAMPLE_BITS-1:0]         c_src;
    logic [SAMPLE_BITS-1:0]         s_src;
    logic                           c_neg;
    logic                           s_neg;
    logic signed [SAMPLE_BITS-1:0]  coef_c;
    logic signed [SAMPLE_BITS-1:0]  coef_s;
    logic signed [SUM_W-1:0]        re_sum;
    logic signed [SUM_W-1:0]        im_sum;
    logic signed [SH_W-1:0]         re_sh;
    logic signed [SH_W-1:0]         im_sh;

    function automatic logic signed [SAMPLE_BITS-1:0] signed_coef(
        input logic [SAMPLE_BITS-1:0] mag, input logic neg);
        logic signed [SAMPLE_BITS:0] ext;
        ext = {1'b0, mag};
        if (neg)               return SAMPLE_BITS'(-ext);
        if (mag[SAMPLE_BITS-1]) return S_MAX;
        return mag;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [SH_W-1:0] v);
        if (v[SH_W-1:SAMPLE_BITS-1] == '0 || v[SH_W-1:SAMPLE_BITS-1] == '1)
            return v[SAMPLE_BITS-1:0];
        return v[SH_W-1] ? S_MIN : S_MAX;
    endfunction

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = !b_valid_reg || out_free;
    assign b_move   = in_ctl.valid && in_ready;

    // quadrant sign pattern on the octant magnitudes
    always_comb begin
        unique case (in_ctl.quad)
            cfsm_pkg::QUAD_0: begin
                c_src = cos_mag; c_neg = 1'b0; s_src = sin_mag; s_neg = 1'b0;
            end
            cfsm_pkg::QUAD_1: begin
                c_src = sin_mag; c_neg = 1'b1; s_src = cos_mag; s_neg = 1'b0;
            end
            cfsm_pkg::QUAD_2: begin
                c_src = cos_mag; c_neg = 1'b1; s_src = sin_mag; s_neg = 1'b1;
            end
            cfsm_pkg::QUAD_3: begin
                c_src = sin_mag; c_neg = 1'b0; s_src = cos_mag; s_neg = 1'b1;
            end
            default: begin
                c_src = cos_mag; c_neg = 1'b0; s_src = sin_mag; s_neg = 1'b0;
            end
        endcase
        coef_c = signed_coef(c_src, c_neg);
        coef_s = signed_coef(s_src, s_neg);
    end

    always_comb begin
        re_sum = SUM_W'(prod_rc_reg) - SUM_W'(prod_is_reg) + HALF_LSB;
        im_sum = SUM_W'(prod_rs_reg) + SUM_W'(prod_ic_reg) + HALF_LSB;
        re_sh  = SH_W'(re_sum >>> (SAMPLE_BITS - 1));
        im_sh  = SH_W'(im_sum >>> (SAMPLE_BITS - 1));
    end

    always_comb begin
        if (b_move)        b_valid_next = 1'b1;
        else if (out_free) b_valid_next = 1'b0;
        else               b_valid_next = b_valid_reg;
        if (b_valid_reg && out_free) out_valid_next = 1'b1;
        else if (out_ready)          out_valid_next = 1'b0;
        else                         out_valid_next = out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_move) begin
            prod_rc_reg <= in_real * coef_c;
            prod_is_reg <= in_imag * coef_s;
            prod_rs_reg <= in_real * coef_s;
            prod_ic_reg <= in_imag * coef_c;
        end
        if (b_valid_reg && out_free) begin
            out_real_reg <= sat(re_sh);
            out_imag_reg <= sat(im_sh);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_real  = out_real_reg;
    assign out_imag  = out_imag_reg;

    `CFSM_ASSERT_NEXT(a_items_kept, aclk, aresetn, !b_move && !(out_valid_reg && out_ready), $countones({b_valid_reg, out_valid_reg}) == $past($countones({b_valid_reg, out_valid_reg})), "item count changed with no transfer")
    `CFSM_ASSERT_NEXT(a_prod_held, aclk, aresetn, b_valid_reg && !out_free, b_valid_reg, "product stage dropped a stalled item")

endmodule

### design/complex_frequency_shift_mixer_core.sv
// nco complex mixer core: one q1.15 i/q request in, one mixed request out
// path: an accepted request moves from the input register through the product register to m_tvalid
// throughput: one request per cycle while m_tready stays high, set by the three-register pipeline
// (input/phasor register, product register, round/saturate output register)
// reset: aresetn low at a clock edge clears phase_step, accumulator and valids
// depends on cfsm_pkg, cfsm_nco, cfsm_cmul and the shared assertion macros
`include "complex_frequency_shift_mixer_core_defines.svh"

module complex_frequency_shift_mixer_core #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS     = 16,
    localparam int TDATA_W        = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration: phase step per request, in units of 2^-32 of a turn
    input  logic                               cfg_wr_en,
    input  logic [cfsm_pkg::STEP_BITS-1:0]     cfg_wr_data,
    // input samples
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [TDATA_W-1:0]                 s_tdata,  // in_real, in_imag, zero pad
    // mixed samples
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [TDATA_W-1:0]                 m_tdata   // out_real, out_imag, zero pad
);

    // input stage registers
    logic                          a_valid_reg;
    logic                          a_valid_next;
    logic signed [SAMPLE_BITS-1:0] a_real_reg;
    logic signed [SAMPLE_BITS-1:0] a_imag_reg;
    logic [SAMPLE_BITS-1:0]        a_sin_reg;
    logic [SAMPLE_BITS-1:0]        a_cos_reg;
    cfsm_pkg::quad_t               a_quad_reg;

    // phasor for the accumulator's current phase
    logic [SAMPLE_BITS-1:0]        nco_sin;
    logic [SAMPLE_BITS-1:0]        nco_cos;
    cfsm_pkg::quad_t               nco_quad;

    cfsm_pkg::phasor_ctl_t         a_ctl;
    logic                          b_ready;
    logic                          s_accept;
    logic signed [SAMPLE_BITS-1:0] out_real;
    logic signed [SAMPLE_BITS-1:0] out_imag;

    // accumulator advances once per accepted request
    cfsm_nco #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_nco (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step_en     (s_accept),
        .sin_mag     (nco_sin),
        .cos_mag     (nco_cos),
        .quad        (nco_quad)
    );

    // input register frees when empty or when the product stage takes it
    assign s_tready = !a_valid_reg || b_ready;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        if (s_accept)     a_valid_next = 1'b1;
        else if (b_ready) a_valid_next = 1'b0;
        else              a_valid_next = a_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    // sample and phasor captured together, phasor is from the pre-advance phase
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_real_reg <= s_tdata[SAMPLE_BITS-1:0];
            a_imag_reg <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            a_sin_reg  <= nco_sin;
            a_cos_reg  <= nco_cos;
            a_quad_reg <= nco_quad;
        end
    end

    assign a_ctl.valid = a_valid_reg;
    assign a_ctl.quad  = a_quad_reg;

    // complex multiply, round half up, saturate
    cfsm_cmul #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cmul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctl    (a_ctl),
        .in_real   (a_real_reg),
        .in_imag   (a_imag_reg),
        .sin_mag   (a_sin_reg),
        .cos_mag   (a_cos_reg),
        .in_ready  (b_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_real  (out_real),
        .out_imag  (out_imag)
    );

    assign m_tdata = TDATA_W'({out_imag, out_real});

    `CFSM_ASSERT_NEXT(a_load_input, aclk, aresetn, s_accept, a_valid_reg, "accepted request not held in input stage")
    `CFSM_ASSERT_NOW(a_stall_cause, aclk, aresetn, !s_tready, a_valid_reg && !b_ready, "input stalled while pipeline could move")

endmodule

### tb/testbench.sv
// self-checking testbench for complex_frequency_shift_mixer_core, the nco i/q mixer
// predicts every mixed request from its own phasor table and phase accumulator
// depends on cfsm_pkg (quad_t and STEP_BITS) and the mixer rtl; nothing else is read
module testbench;

    localparam int     TDATA_W         = 32;
    localparam int     FRAC_BITS       = 15;
    localparam int     LUT_SIZE        = 1024;
    localparam int     QUARTER         = LUT_SIZE / 4;
    localparam longint UNIT            = 64'sd1000000000;
    localparam longint PI_FX           = 64'sd3141592654;
    localparam longint SAMPLE_MAX      = 64'sd32767;
    localparam longint SAMPLE_MIN      = -64'sd32768;
    localparam int     PIPE_SETTLE     = 6;      // three-stage pipe plus margin
    localparam int     HOLD_OFF_CYCLES = 400;
    localparam int     CYCLE_LIMIT     = 100000;

    typedef struct {
        logic signed [15:0] re;
        logic signed [15:0] im;
    } iq_t;

    // all inputs known from time zero
    logic                           aclk        = 1'b0;
    logic                           aresetn     = 1'b0;
    logic                           cfg_wr_en   = 1'b0;
    logic [cfsm_pkg::STEP_BITS-1:0] cfg_wr_data = '0;
    logic                           s_tvalid    = 1'b0;
    logic                           s_tready;
    logic [TDATA_W-1:0]             s_tdata     = '0;   // in_real, in_imag
    logic                           m_tvalid;
    logic                           m_tready    = 1'b0;
    logic [TDATA_W-1:0]             m_tdata;            // out_real, out_imag

    // predictor state: its own copy of the step register and the accumulator
    logic signed [15:0]     cos_lut [LUT_SIZE];
    logic signed [15:0]     sin_lut [LUT_SIZE];
    logic [31:0]            model_step;
    logic [31:0]            model_phase;
    iq_t                    pending_mixed [$];

    int                     tx_idle_pct = 6;
    int                     rx_idle_pct = 68;
    bit                     hold_active = 1'b0;
    event                   hold_off_start;
    int                     mismatches  = 0;
    int                     n_sent      = 0;
    int                     n_checked   = 0;
    int                     n_settings  = 0;

    complex_frequency_shift_mixer_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // fixed-point value scaled by UNIT to q1.15, nearest with ties away from zero;
    // +1.0 is not representable and clamps, -1.0 stays exact
    function automatic logic signed [15:0] quantize(input longint v);
        longint mag;
        longint q;
        mag = (v < 0) ? -v : v;
        q   = (mag * 32768 + UNIT / 2) / UNIT;
        if (v < 0) q = -q;
        if (q > SAMPLE_MAX) q = SAMPLE_MAX;
        if (q < SAMPLE_MIN) q = SAMPLE_MIN;
        return 16'(q);
    endfunction

    // add half an lsb, floor-shift (round half toward +inf), then clamp
    function automatic logic signed [15:0] round_saturate(input longint v);
        longint r;
        r = (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (r > SAMPLE_MAX) r = SAMPLE_MAX;
        if (r < SAMPLE_MIN) r = SAMPLE_MIN;
        return 16'(r);
    endfunction

    // rotate one sample by the phasor at the top ten accumulator bits, then step
    function automatic iq_t mix_with_phasor(input logic signed [15:0] re,
                                            input logic signed [15:0] im);
        logic [9:0] idx;
        longint     c;
        longint     s;
        iq_t        r;
        idx  = model_phase[31:22];
        c    = cos_lut[idx];
        s    = sin_lut[idx];
        r.re = round_saturate(longint'(re) * c - longint'(im) * s);
        r.im = round_saturate(longint'(re) * s + longint'(im) * c);
        model_phase = model_phase + model_step;
        return r;
    endfunction

    // phasor table: taylor series over one octant, mirrored into the other seven
    initial begin : phasor_lut_init
        int     k;
        int     r;
        int     n;
        bit     swap;
        longint x;
        longint ts;
        longint tc;
        longint sv;
        longint cv;
        longint t;
        for (k = 0; k < LUT_SIZE; k++) begin
            r    = k % QUARTER;
            swap = 1'b0;
            // second octant of each quadrant folds back onto the first
            if (r > QUARTER / 2) begin
                r    = QUARTER - r;
                swap = 1'b1;
            end
            x  = (2 * PI_FX * longint'(r) + LUT_SIZE / 2) / LUT_SIZE;
            ts = x;
            tc = UNIT;
            sv = x;
            cv = UNIT;
            for (n = 1; n <= 8; n++) begin
                ts = ts * x / UNIT * x / UNIT / longint'((2 * n) * (2 * n + 1));
                tc = tc * x / UNIT * x / UNIT / longint'((2 * n - 1) * (2 * n));
                if (n % 2 == 1) begin
                    sv = sv - ts;
                    cv = cv - tc;
                end else begin
                    sv = sv + ts;
                    cv = cv + tc;
                end
            end
            if (swap) begin
                t  = sv;
                sv = cv;
                cv = t;
            end
            case (cfsm_pkg::quad_t'(k[9:8]))
                cfsm_pkg::QUAD_0: begin
                    cos_lut[k] = quantize(cv);
                    sin_lut[k] = quantize(sv);
                end
                cfsm_pkg::QUAD_1: begin
                    cos_lut[k] = quantize(-sv);
                    sin_lut[k] = quantize(cv);
                end
                cfsm_pkg::QUAD_2: begin
                    cos_lut[k] = quantize(-cv);
                    sin_lut[k] = quantize(-sv);
                end
                default: begin
                    cos_lut[k] = quantize(sv);
                    sin_lut[k] = quantize(-cv);
                end
            endcase
        end
    end

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) $display("mismatch: %s", what);
    endtask

    // one edge-sampled process: register writes and accepted input requests
    // update the predictor, accepted output requests are checked in order
    always @(posedge aclk) begin : mixer_scoreboard
        iq_t want;
        iq_t got;
        if (!aresetn) begin
            model_step  = '0;
            model_phase = '0;
            pending_mixed.delete();
        end else begin
            if (cfg_wr_en) model_step = cfg_wr_data;
            if (s_tvalid && s_tready)
                pending_mixed.push_back(mix_with_phasor(s_tdata[15:0], s_tdata[31:16]));
            if (m_tvalid && m_tready) begin
                got.re = m_tdata[15:0];
                got.im = m_tdata[31:16];
                if (pending_mixed.size() == 0) begin
                    note_mismatch($sformatf("unexpected request re=%0d im=%0d",
                                            got.re, got.im));
                end else begin
                    want = pending_mixed.pop_front();
                    n_checked++;
                    if (got.re !== want.re)
                        note_mismatch($sformatf("request %0d out_real expected %0d got %0d",
                                                n_checked, want.re, got.re));
                    if (got.im !== want.im)
                        note_mismatch($sformatf("request %0d out_imag expected %0d got %0d",
                                                n_checked, want.im, got.im));
                end
            end
        end
    end

    // receiver: random stalls, forced low during a hold-off stretch
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !hold_active && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // long output hold-off, counted on its own so the sender keeps going
    initial forever begin
        @(hold_off_start);
        hold_active = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge aclk);
        hold_active = 1'b0;
    end

    // called right after a falling edge; returns right after a falling edge once the request is accepted,
    // with valid left high, so back-to-back requests need no gap
    task automatic send_sample(input logic signed [15:0] re, input logic signed [15:0] im);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {im, re};
        do @(posedge aclk); while (!s_tready);
        n_sent++;
        @(negedge aclk);
    endtask

    // stop offering and wait until every expected request has come out
    task automatic drain_pipeline();
        s_tvalid = 1'b0;
        while (pending_mixed.size() != 0) @(negedge aclk);
        repeat (PIPE_SETTLE) @(negedge aclk);
    endtask

    // the step register is only written while the pipe is empty
    task automatic load_phase_step(input logic [31:0] step);
        drain_pipeline();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = step;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        n_settings++;
    endtask

    // mostly uniform, with the rails and tiny values mixed in
    function automatic logic signed [15:0] random_sample();
        logic signed [15:0] v;
        case ($urandom_range(9))
            0:       v = 16'(SAMPLE_MIN);
            1:       v = 16'(SAMPLE_MAX);
            2:       v = 16'(int'($urandom_range(8)) - 4);
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    task automatic run_random_stream(input logic [31:0] step, input int count);
        load_phase_step(step);
        repeat (count) send_sample(random_sample(), random_sample());
        drain_pipeline();
    endtask

    // step is zero after reset: phase stays at 0, cos at the clamped +1.0,
    // so these hit the unity-gain rounding including an exact half lsb
    task automatic test_reset_state();
        send_sample(16'(SAMPLE_MAX), 16'(SAMPLE_MIN));
        send_sample(16'sd16384, -16'sd16384);
        send_sample(-16'sd16384, 16'sd16384);
        send_sample(16'sd0, 16'sd0);
        drain_pipeline();
    endtask

    // eighth-turn step visits every octant boundary, including the exact -1.0
    // cosine where full-scale inputs saturate
    task automatic test_field_extremes();
        logic signed [15:0] rails_re [4];
        logic signed [15:0] rails_im [4];
        int                 i;
        int                 p;
        rails_re = '{16'(SAMPLE_MIN), 16'(SAMPLE_MAX), 16'(SAMPLE_MIN), 16'(SAMPLE_MAX)};
        rails_im = '{16'(SAMPLE_MIN), 16'(SAMPLE_MAX), 16'(SAMPLE_MAX), 16'(SAMPLE_MIN)};
        load_phase_step(32'h2000_0000);
        for (i = 0; i < 16; i++) begin
            p = (i + i / 8) % 4;
            send_sample(rails_re[p], rails_im[p]);
        end
        drain_pipeline();
    endtask

    task automatic test_sender_light();
        tx_idle_pct = 6;
        rx_idle_pct = 68;
        run_random_stream($urandom, 300);
        run_random_stream(32'hFFFF_FFFF, 150);
    endtask

    task automatic test_receiver_light();
        tx_idle_pct = 68;
        rx_idle_pct = 6;
        run_random_stream(32'h8000_0000, 100);
        // steps up to one table entry exercise phase truncation
        run_random_stream($urandom_range(1, 1 << 22), 150);
    endtask

    task automatic test_full_rate();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random_stream(32'h0000_0000, 100);
        run_random_stream(32'h4000_0000, 100);
        run_random_stream($urandom, 150);
    endtask

    // receiver stalls for a long stretch while the sender keeps offering,
    // so the pipe fills and s_tready has to drop
    task automatic test_output_hold_off();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_phase_step($urandom);
        -> hold_off_start;
        repeat (100) send_sample(random_sample(), random_sample());
        drain_pipeline();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_reset_state();
        test_field_extremes();
        test_sender_light();
        test_receiver_light();
        test_full_rate();
        test_output_hold_off();

        drain_pipeline();
        if (pending_mixed.size() != 0)
            note_mismatch($sformatf("%0d requests never came out", pending_mixed.size()));
        $display("sent %0d samples under %0d phase step settings, compared %0d results",
                 n_sent, n_settings, n_checked);
        $display("steps covered zero, all ones, half and quarter turn, sub-entry steps, and a %0d-cycle output stall",
                 HOLD_OFF_CYCLES);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // watchdog against a hung handshake
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

endmodule
